// File: rtl/chd_pkg.sv
`timescale 1ns / 1ps

package chd_pkg;

  localparam int LEN_BITS = 24;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Result item kind, carried on the master tuser.
  typedef enum logic [2:0] {
    ST_FRAME   = 3'd0,
    ST_PAYLOAD = 3'd1,
    ST_CHUNK   = 3'd2,
    ST_LAST    = 3'd3,
    ST_ERROR   = 3'd4,
    ST_IGNORED = 3'd5
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [7:0]           payload_byte;
    logic [LEN_BITS-1:0]  chunk_length;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  // Accepts 0-9, a-f and A-F only.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b0;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.valid = 1'b1;
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.valid = 1'b1;
      h.value = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

// File: rtl/chd_parser.sv
`timescale 1ns / 1ps

module chd_parser #(
  parameter int SIZE_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        data_byte,
  input  logic              start_of_body,
  output chd_pkg::result_t  result
);
  import chd_pkg::*;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_SIZE_LF = 3'd1,
    PH_DATA    = 3'd2,
    PH_DATA_CR = 3'd3,
    PH_DATA_LF = 3'd4,
    PH_DONE    = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  phase_t               phase, phase_next, cur_phase;
  logic [SIZE_BITS-1:0] size_accum, size_accum_next, cur_accum;
  logic                 have_digit, have_digit_next, cur_have;
  logic [SIZE_BITS-1:0] bytes_left, bytes_left_next, cur_left;
  logic                 len_sel;
  hex_t                 hex;
  logic [LEN_BITS+SIZE_BITS-1:0] len_wide;

  assign hex = hex_decode(data_byte);

  always_comb begin
    // A start-of-body item sees freshly cleared state.
    cur_phase = start_of_body ? PH_SIZE : phase;
    cur_accum = start_of_body ? '0 : size_accum;
    cur_have  = start_of_body ? 1'b0 : have_digit;
    cur_left  = start_of_body ? '0 : bytes_left;

    phase_next      = cur_phase;
    size_accum_next = cur_accum;
    have_digit_next = cur_have;
    bytes_left_next = cur_left;
    result.status       = ST_FRAME;
    result.payload_byte = 8'd0;
    len_sel             = 1'b0;

    unique case (cur_phase)
      PH_SIZE: begin
        if (hex.valid) begin
          // Shifting in a digit overflows exactly when the top nibble is set.
          if (|cur_accum[SIZE_BITS-1 -: 4]) begin
            phase_next    = PH_ERROR;
            result.status = ST_ERROR;
          end else begin
            size_accum_next = {cur_accum[SIZE_BITS-5:0], hex.value};
            have_digit_next = 1'b1;
          end
        end else if (data_byte == CH_CR && cur_have) begin
          phase_next = PH_SIZE_LF;
        end else begin
          phase_next    = PH_ERROR;
          result.status = ST_ERROR;
        end
      end
      PH_SIZE_LF: begin
        if (data_byte == CH_LF) begin
          bytes_left_next = cur_accum;
          phase_next      = (cur_accum == '0) ? PH_DATA_CR : PH_DATA;
        end else begin
          phase_next    = PH_ERROR;
          result.status = ST_ERROR;
        end
      end
      PH_DATA: begin
        result.status       = ST_PAYLOAD;
        result.payload_byte = data_byte;
        if (cur_left != '0) begin
          bytes_left_next = cur_left - 1'b1;
        end
        if (cur_left <= SIZE_BITS'(1)) begin
          phase_next = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (data_byte == CH_CR) begin
          phase_next = PH_DATA_LF;
        end else begin
          phase_next    = PH_ERROR;
          result.status = ST_ERROR;
        end
      end
      PH_DATA_LF: begin
        if (data_byte == CH_LF) begin
          len_sel = 1'b1;
          if (cur_accum == '0) begin
            result.status = ST_LAST;
            phase_next    = PH_DONE;
          end else begin
            result.status   = ST_CHUNK;
            phase_next      = PH_SIZE;
            size_accum_next = '0;
            have_digit_next = 1'b0;
            bytes_left_next = '0;
          end
        end else begin
          phase_next    = PH_ERROR;
          result.status = ST_ERROR;
        end
      end
      PH_DONE: begin
        result.status = ST_IGNORED;
      end
      default: begin
        phase_next    = PH_ERROR;
        result.status = ST_ERROR;
      end
    endcase

    len_wide            = {{LEN_BITS{1'b0}}, cur_accum};
    result.chunk_length = len_sel ? len_wide[LEN_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SIZE;
      size_accum <= '0;
      have_digit <= 1'b0;
      bytes_left <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      size_accum <= size_accum_next;
      have_digit <= have_digit_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

// File: rtl/chd_result_reg.sv
`timescale 1ns / 1ps

module chd_result_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  chd_pkg::result_t  result_in,
  input  logic              ready,
  output logic              valid,
  output chd_pkg::result_t  result_out
);
  import chd_pkg::*;

  // Loading and draining in the same cycle keeps valid high.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

// File: rtl/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// HTTP chunked body decoder, one raw body byte per item.
// Slave channel: s_tdata carries the raw byte, s_tuser[0] marks the first
// byte of a new body and clears all parse state before that byte is handled.
// Master channel: exactly one result item per input item. m_tuser gives the
// status (framing, payload, chunk done, last chunk done, error, ignored),
// m_tdata holds the payload byte and the length of a completed chunk.
// Path: each input item goes into one input register, then through the parse
// logic into the result register, which presents the result item.
// Throughput: one item per cycle while the receiver is ready; the parse state
// is a single small update per byte, held in the state register's own loop.
// Reset clears the parse state to "awaiting size digits" and empties both
// registers. When the receiver stalls, the result register holds its item,
// the input register holds the next one, and s_tready drops only when both
// are full; nothing is lost or repeated.
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] start_of_body
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] payload_byte, [31:8] chunk_length
  output logic [2:0]  m_tuser    // [2:0] status
);
  import chd_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_sob;
  logic       advance;
  result_t    step_result;
  result_t    out_result;

  // The item in the input register moves on whenever the result register
  // is empty or is being drained in this cycle.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_sob  <= s_tuser[0];
    end
  end

  chd_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .data_byte     (in_byte),
    .start_of_body (in_sob),
    .result        (step_result)
  );

  chd_result_reg u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .result_in  (step_result),
    .ready      (m_tready),
    .valid      (m_tvalid),
    .result_out (out_result)
  );

  assign m_tdata = {out_result.chunk_length, out_result.payload_byte};
  assign m_tuser = out_result.status;

endmodule

// File: rtl/chd_checker.sv
`timescale 1ns / 1ps

module chd_stream_asserts (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser
);
  import chd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> m_tuser <= ST_IGNORED)
    else $error("status code out of range");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tuser != ST_PAYLOAD |-> m_tdata[7:0] == 8'd0)
    else $error("payload byte set on a non-payload result");

  a_length_zero: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tuser != ST_CHUNK && m_tuser != ST_LAST
      |-> m_tdata[31:8] == 24'd0)
    else $error("chunk length set on a result that closes no chunk");

endmodule

bind http_chunked_body_decoder chd_stream_asserts u_chd_stream_asserts (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: tb/chd_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the chunked body decoder, predicts one result per
// accepted input item and compares it field by field with what comes out.
module chd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [2:0]  m_tuser,
  output int          pending,
  output int          fail_count
);

  import chd_pkg::*;

  typedef enum logic [2:0] {
    AWAIT_DIGITS  = 3'd0,
    AWAIT_SIZE_LF = 3'd1,
    IN_PAYLOAD    = 3'd2,
    AWAIT_DATA_CR = 3'd3,
    AWAIT_DATA_LF = 3'd4,
    BODY_DONE     = 3'd5,
    STUCK_ERROR   = 3'd6
  } parse_phase_t;

  parse_phase_t        phase;
  logic [LEN_BITS-1:0] size_acc;
  logic                seen_digit;
  logic [LEN_BITS-1:0] remaining;
  result_t             expected_q[$];

  function automatic void restart_size_line();
    phase      = AWAIT_DIGITS;
    size_acc   = '0;
    seen_digit = 1'b0;
    remaining  = '0;
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  // Advances the parse state by one byte and returns the result it causes.
  function automatic result_t decode_byte(input logic [7:0] c, input logic sob);
    result_t    r;
    logic [4:0] nib;
    r.status       = ST_FRAME;
    r.payload_byte = '0;
    r.chunk_length = '0;
    if (sob) restart_size_line();
    case (phase)
      AWAIT_DIGITS: begin
        nib = hex_nibble(c);
        if (nib[4]) begin
          // Another digit would push the size past the counter width.
          if (size_acc[LEN_BITS-1 -: 4] != 4'd0) begin
            phase    = STUCK_ERROR;
            r.status = ST_ERROR;
          end else begin
            size_acc   = {size_acc[LEN_BITS-5:0], nib[3:0]};
            seen_digit = 1'b1;
          end
        end else if (c == CH_CR && seen_digit) begin
          phase = AWAIT_SIZE_LF;
        end else begin
          phase    = STUCK_ERROR;
          r.status = ST_ERROR;
        end
      end
      AWAIT_SIZE_LF: begin
        if (c == CH_LF) begin
          remaining = size_acc;
          phase     = (size_acc == '0) ? AWAIT_DATA_CR : IN_PAYLOAD;
        end else begin
          phase    = STUCK_ERROR;
          r.status = ST_ERROR;
        end
      end
      IN_PAYLOAD: begin
        r.status       = ST_PAYLOAD;
        r.payload_byte = c;
        if (remaining != '0) remaining = remaining - 1'b1;
        if (remaining == '0) phase = AWAIT_DATA_CR;
      end
      AWAIT_DATA_CR: begin
        if (c == CH_CR) begin
          phase = AWAIT_DATA_LF;
        end else begin
          phase    = STUCK_ERROR;
          r.status = ST_ERROR;
        end
      end
      AWAIT_DATA_LF: begin
        if (c == CH_LF) begin
          r.chunk_length = size_acc;
          if (size_acc == '0) begin
            r.status = ST_LAST;
            phase    = BODY_DONE;
          end else begin
            r.status = ST_CHUNK;
            restart_size_line();
          end
        end else begin
          phase    = STUCK_ERROR;
          r.status = ST_ERROR;
        end
      end
      BODY_DONE: begin
        r.status = ST_IGNORED;
      end
      default: begin
        phase    = STUCK_ERROR;
        r.status = ST_ERROR;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      restart_size_line();
      expected_q.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      // Results are compared first; an input taken at this edge cannot
      // have its result out at the same edge.
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("%0t: result item with nothing expected: status %0d data %h",
                     $realtime, m_tuser, m_tdata);
        end else begin
          want = expected_q.pop_front();
          if (m_tuser !== want.status || m_tdata[7:0] !== want.payload_byte ||
              m_tdata[31:8] !== want.chunk_length) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display("%0t: mismatch: expected status %0d byte %h length %h,",
                       $realtime, want.status, want.payload_byte, want.chunk_length,
                       " got status %0d byte %h length %h",
                       m_tuser, m_tdata[7:0], m_tdata[31:8]);
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_q.insert(expected_q.size(), decode_byte(s_tdata, s_tuser[0]));
      pending <= expected_q.size();
    end
  end

endmodule

// File: tb/http_chunked_body_decoder_tb.sv
`timescale 1ns / 1ps

// Top of the decoder bench. It builds streams of chunked bodies, drives them
// in bursts, stalls the result channel, and gives the verdict. All prediction
// and comparison lives in the checker instance.
module http_chunked_body_decoder_tb;

  import chd_pkg::*;

  // Cycles without any handshake before the run is declared hung. The
  // slowest legal stretch is a sender gap plus a few stalled results.
  localparam int HANG_LIMIT = 5000;
  localparam int ITEM_TARGET = 950;

  typedef struct packed {
    logic [7:0] data;
    logic       sob;
  } body_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic [0:0] s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;

  int pending;
  int fail_count;

  body_item_t stream_q[$];
  logic       next_sob = 1'b0;
  int         counted = 0;

  int ready_mode = 0;
  int mode_left = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  http_chunked_body_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  chd_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // The receiver switches between random modes: always ready, mostly ready,
  // mostly stalled, and strict alternation.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(16, 96);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ~m_tready;
    endcase
  end

  // Hang detection: any accepted item on either side clears the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Queues one raw byte; the first byte after next_sob is set opens a body.
  function automatic void push_byte(input logic [7:0] b);
    body_item_t item;
    item.data = b;
    item.sob  = next_sob;
    stream_q.insert(stream_q.size(), item);
    next_sob = 1'b0;
    counted++;
  endfunction

  function automatic void push_crlf();
    push_byte(CH_CR);
    push_byte(CH_LF);
  endfunction

  // Emits the low ndig hex digits of v, most significant first, each digit
  // in a random case.
  function automatic void push_hex_digits(input logic [31:0] v, input int ndig);
    logic [3:0] d;
    for (int i = ndig - 1; i >= 0; i--) begin
      d = 4'(v >> (4 * i));
      if (d < 4'd10)
        push_byte(8'("0") + 8'(d));
      else if ($urandom_range(0, 1) == 0)
        push_byte(8'("a") + 8'(d) - 8'd10);
      else
        push_byte(8'("A") + 8'(d) - 8'd10);
    end
  endfunction

  // Size line with pad leading zeros, closed by CR LF.
  function automatic void push_size_line(input int sz, input int pad);
    int ndig;
    ndig = 1;
    while ((sz >> (4 * ndig)) != 0) ndig++;
    push_hex_digits(sz, ndig + pad);
    push_crlf();
  endfunction

  // Short directed walk: every status, byte extremes, and several framing faults.
  function automatic void build_directed();
    // Two-byte chunk carrying the smallest and largest byte values.
    next_sob = 1'b1;
    push_size_line(2, 0);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_crlf();
    // Zero-size chunk ends the body; the byte after it is ignored.
    push_size_line(0, 0);
    push_crlf();
    push_byte("A");
    // Non-hex on the size line, then the error sticks.
    next_sob = 1'b1;
    push_byte("g");
    push_byte("1");
    // Empty size line.
    next_sob = 1'b1;
    push_byte(CH_CR);
    // Largest size that fits, then one digit too many.
    next_sob = 1'b1;
    push_byte("f");
    push_byte("F");
    push_byte("f");
    push_byte("F");
    push_byte("f");
    push_byte("F");
    push_byte("0");
    // Size line CR not followed by LF.
    next_sob = 1'b1;
    push_byte("a");
    push_byte(CH_CR);
    push_byte("x");
    // Payload not followed by CR.
    next_sob = 1'b1;
    push_size_line(1, 0);
    push_byte(8'h55);
    push_byte("x");
  endfunction

  // One mostly well-formed body; some get a corrupted byte or are cut short.
  function automatic void build_body();
    int         nchunks;
    int         sz;
    int         start;
    int         k;
    logic [7:0] b;
    body_item_t item;
    start    = stream_q.size();
    next_sob = 1'b1;
    nchunks  = $urandom_range(0, 4);
    repeat (nchunks) begin
      case ($urandom_range(0, 9))
        7, 8:    sz = $urandom_range(17, 64);
        9:       sz = $urandom_range(65, 300);
        default: sz = $urandom_range(1, 16);
      endcase
      push_size_line(sz, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
      repeat (sz) begin
        case ($urandom_range(0, 15))
          0:       b = CH_CR;
          1:       b = CH_LF;
          2:       b = 8'h00;
          3:       b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        push_byte(b);
      end
      push_crlf();
    end
    if ($urandom_range(0, 7) != 0) begin
      push_size_line(0, $urandom_range(0, 1));
      push_crlf();
      // Trailing bytes after the body are ignored and not counted.
      repeat ($urandom_range(0, 3)) begin
        push_byte(8'($urandom_range(0, 255)));
        counted--;
      end
    end
    if (stream_q.size() > start + 1) begin
      if ($urandom_range(0, 5) == 0) begin
        k = $urandom_range(start + 1, stream_q.size() - 1);
        item = stream_q[k];
        item.data = 8'($urandom_range(0, 255));
        stream_q[k] = item;
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, stream_q.size() - start - 1)) void'(stream_q.pop_back());
      end
    end
  endfunction

  // Size line of up to eight random digits: large sizes, often overflowing,
  // followed by a few payload bytes before the next body cuts in.
  function automatic void build_size_probe();
    next_sob = 1'b1;
    push_hex_digits($urandom, $urandom_range(1, 8));
    push_crlf();
    repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)));
  endfunction

  // Raw noise with start-of-body set now and then.
  function automatic void build_noise();
    repeat ($urandom_range(1, 10)) begin
      next_sob = ($urandom_range(0, 3) == 0);
      push_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_random(input int upto);
    while (counted < upto) begin
      case ($urandom_range(0, 11))
        0:       build_size_probe();
        1:       build_noise();
        default: build_body();
      endcase
    end
  endfunction

  // Sends the queued items in bursts of random length with random gaps.
  task automatic send_stream();
    int         burst;
    int         gap;
    body_item_t item;
    gap = 0;
    while (stream_q.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && stream_q.size() != 0) begin
        item = stream_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= item.data;
        s_tuser  <= item.sob;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        s_tdata  <= 8'($urandom_range(0, 255));
        s_tuser  <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk);
      end
    end
    if (gap == 0) s_tvalid <= 1'b0;
  endtask

  // Holds the sender until every expected result has been seen.
  task automatic wait_results();
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    build_directed();
    send_stream();
    wait_results();

    // The random part is sent in two halves with a full drain between them.
    build_random(ITEM_TARGET / 2);
    send_stream();
    wait_results();
    build_random(ITEM_TARGET);
    send_stream();
    wait_results();

    // The block holds at most two items, so a short final wait covers any stray one.
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
